[sv/bta_pkg.sv]
// Package for the buddy tree allocator: default parameters, field widths,
// datapath command codes and the status group shared by controller and datapath.
// No dependencies.
package bta_pkg;

   localparam int LEVELS_DEF          = 16;
   localparam int MIN_BLOCK_BYTES_DEF = 8;

   localparam int REQ_W  = 32;
   localparam int OFF_W  = 18;
   localparam int MAXB_W = 19;
   localparam logic [MAXB_W-1:0] MAXB_RESET = 19'd262144;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLR_STEP,
      OP_LOAD,
      OP_P_STEP,
      OP_K_STEP,
      OP_S_INIT,
      OP_S_DOWN,
      OP_S_UP,
      OP_S_NEXT,
      OP_FOUND,
      OP_U_STEP,
      OP_DIV_STEP,
      OP_OWN_LOAD,
      OP_D_STEP,
      OP_R_START,
      OP_ALLOC_OK,
      OP_REL_OK,
      OP_FAIL
   } bta_op_type;

   typedef struct packed {
      bta_op_type op;
   } bta_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic func;
      logic too_large;
      logic off_out;
      logic p_lt_req;
      logic mb_ge_p;
      logic kexp_last;
      logic cnt_ge_k;
      logic at_target;
      logic node_odd;
      logic node_root;
      logic own_zero;
      logic rsp_free;
   } bta_status_type;

endpackage

[sv/bta_dpath.sv]
// Datapath of the buddy tree allocator: count and owner memories, size and
// search registers, offset-to-leaf multiplier and the result register. Uses bta_pkg.
module bta_dpath
   import bta_pkg::*;
#(
   parameter int LEVELS          = LEVELS_DEF,
   parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bta_cmd_type          cmd,
   output bta_status_type       status,
   input  logic                 req_func,
   input  logic [REQ_W-1:0]     req_request_bytes,
   input  logic [OFF_W-1:0]     req_release_offset,
   input  logic                 csr_write,
   input  logic [MAXB_W-1:0]    csr_max_block_bytes,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_granted,
   output logic [OFF_W-1:0]     rsp_block_offset
);

   localparam int NW    = LEVELS;
   localparam int LW    = LEVELS - 1;
   localparam int CW    = LEVELS;
   localparam int KW    = $clog2(LEVELS);
   localparam int PW    = LW + 32;
   localparam int NODES = 1 << LEVELS;
   localparam int LEAF  = 1 << (LEVELS - 1);
   localparam logic [39:0] MEM_BYTES = 40'(MIN_BLOCK_BYTES) << (LEVELS - 1);
   localparam logic [KW-1:0] TOP_DEPTH = KW'(LEVELS - 1);

   // The leaf index is offset / MIN_BLOCK_BYTES, taken as a multiply by a rounded-up
   // reciprocal; the extra shift bits keep it exact for every offset of OFF_W bits.
   localparam int DSH = OFF_W + $clog2(MIN_BLOCK_BYTES);
   localparam int MW  = OFF_W + 2;
   localparam int QW  = DSH + OFF_W;
   localparam longint unsigned DMUL_L =
      ((64'd1 << DSH) + 64'(MIN_BLOCK_BYTES) - 64'd1) / 64'(MIN_BLOCK_BYTES);
   localparam logic [MW-1:0] DMUL = MW'(DMUL_L);

   logic [CW-1:0] cnt_mem [0:NODES-1];
   logic [NW-1:0] own_mem [0:LEAF-1];

   logic [MAXB_W-1:0] max_ff;
   logic              func_ff;
   logic [REQ_W-1:0]  req_ff;
   logic [OFF_W-1:0]  off_ff, quo_ff;
   logic [19:0]       p_ff;
   logic [39:0]       mb_ff;
   logic [KW-1:0]     kexp_ff, dep_ff, td_ff, fdep_ff;
   logic [CW-1:0]     blk_ff, val_ff, cnt_rd_ff;
   logic [NW-1:0]     node_ff, fnode_ff, own_ff, own_rd_ff;
   logic              rsp_valid_ff, granted_ff;
   logic [OFF_W-1:0]  offset_ff;

   logic [NW-1:0]     node_in, fnode_shift;
   logic [CW-1:0]     val_in, cnt_wr;
   logic [CW:0]       cnt_sum;
   logic [QW-1:0]     quo_prod;
   logic              rsp_free, cnt_we;
   logic [LW-1:0]     leaf_idx, own_addr;
   logic [PW-1:0]     byte_off;
   logic [KW-1:0]     leaf_shift;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Start of the allocated block: the node index shifted down to the leaf row.
   assign leaf_shift  = TOP_DEPTH - fdep_ff;
   assign fnode_shift = fnode_ff << leaf_shift;
   assign leaf_idx    = fnode_shift[LW-1:0];
   assign byte_off    = PW'(leaf_idx) * PW'(MIN_BLOCK_BYTES);
   assign own_addr    = LW'(quo_ff);

   assign quo_prod = QW'(off_ff) * QW'(DMUL);

   assign cnt_sum = {1'b0, cnt_rd_ff} + {1'b0, blk_ff};
   always_comb begin
      cnt_we = 1'b0;
      cnt_wr = val_ff;
      if (cmd.op == OP_CLR_STEP) begin
         cnt_we = 1'b1;
      end else if (cmd.op == OP_U_STEP) begin
         cnt_we = 1'b1;
         if (!func_ff) begin
            cnt_wr = cnt_rd_ff - blk_ff;
         end else if (cnt_sum[CW]) begin
            cnt_wr = '1;
         end else begin
            cnt_wr = cnt_sum[CW-1:0];
         end
      end
   end

   always_comb begin
      node_in = node_ff + NW'(1);
      val_in  = val_ff;
      if ((node_ff & node_in) == '0) begin
         val_in = val_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[node_ff] <= cnt_wr;
      end
      cnt_rd_ff <= cnt_mem[node_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ALLOC_OK) begin
         own_mem[leaf_idx] <= fnode_ff;
      end
      own_rd_ff <= own_mem[own_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= MAXB_RESET;
         node_ff      <= NW'(1);
         val_ff       <= CW'(LEAF);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            max_ff <= csr_max_block_bytes;
         end
         if (cmd.op inside {OP_ALLOC_OK, OP_REL_OK, OP_FAIL}) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_CLR_STEP: begin
               node_ff <= node_in;
               val_ff  <= val_in;
            end
            OP_LOAD: begin
               func_ff    <= req_func;
               req_ff     <= req_request_bytes;
               off_ff     <= req_release_offset;
               quo_ff     <= '0;
               p_ff       <= 20'd1;
               mb_ff      <= 40'(MIN_BLOCK_BYTES);
               kexp_ff    <= '0;
               blk_ff     <= CW'(1);
            end
            OP_P_STEP: p_ff <= p_ff << 1;
            OP_K_STEP: begin
               mb_ff   <= mb_ff << 1;
               kexp_ff <= kexp_ff + KW'(1);
               blk_ff  <= blk_ff << 1;
            end
            OP_S_INIT: begin
               node_ff <= NW'(1);
               dep_ff  <= '0;
               td_ff   <= TOP_DEPTH - kexp_ff;
            end
            OP_S_DOWN: begin
               node_ff <= node_ff << 1;
               dep_ff  <= dep_ff + KW'(1);
            end
            OP_S_UP: begin
               node_ff <= node_ff >> 1;
               dep_ff  <= dep_ff - KW'(1);
            end
            OP_S_NEXT: node_ff <= node_in;
            OP_FOUND: begin
               fnode_ff <= node_ff;
               fdep_ff  <= dep_ff;
            end
            OP_U_STEP: node_ff <= node_ff >> 1;
            OP_DIV_STEP: quo_ff <= quo_prod[DSH +: OFF_W];
            OP_OWN_LOAD: begin
               own_ff  <= own_rd_ff;
               node_ff <= own_rd_ff;
               blk_ff  <= CW'(LEAF);
            end
            OP_D_STEP: begin
               node_ff <= node_ff >> 1;
               blk_ff  <= blk_ff >> 1;
            end
            OP_R_START: node_ff <= own_ff;
            OP_ALLOC_OK: begin
               granted_ff   <= 1'b1;
               offset_ff    <= byte_off[OFF_W-1:0];
            end
            OP_REL_OK: begin
               granted_ff   <= 1'b1;
               offset_ff    <= '0;
            end
            OP_FAIL: begin
               granted_ff   <= 1'b0;
               offset_ff    <= '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      status.clr_last  = &node_ff;
      status.func      = func_ff;
      status.too_large = (40'(req_ff) > 40'(max_ff)) || (40'(req_ff) > MEM_BYTES);
      status.off_out   = 40'(off_ff) >= MEM_BYTES;
      status.p_lt_req  = 32'(p_ff) < req_ff;
      status.mb_ge_p   = mb_ff >= 40'(p_ff);
      status.kexp_last = kexp_ff == TOP_DEPTH;
      status.cnt_ge_k  = cnt_rd_ff >= blk_ff;
      status.at_target = dep_ff == td_ff;
      status.node_odd  = node_ff[0];
      status.node_root = node_ff == NW'(1);
      status.own_zero  = own_ff == '0;
      status.rsp_free  = rsp_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = granted_ff;
   assign rsp_block_offset = offset_ff;

endmodule

[sv/bta_ctrl.sv]
// Controller of the buddy tree allocator: sequences the clearing pass, size
// rounding, tree search, path update and release lookup. Uses bta_pkg.
module bta_ctrl
   import bta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  bta_status_type status,
   output bta_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_PSIZE, ST_KSIZE, ST_S_WAIT, ST_S_EVAL,
      ST_S_BACK, ST_U_WAIT, ST_U_WRITE, ST_R_DIV, ST_R_ORD, ST_R_OWN,
      ST_R_DEPTH, ST_DONE_ALLOC, ST_DONE_REL, ST_DONE_FAIL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLR_STEP;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.func) begin
               state_in = status.off_out ? ST_DONE_FAIL : ST_R_DIV;
            end else begin
               state_in = status.too_large ? ST_DONE_FAIL : ST_PSIZE;
            end
         end
         ST_PSIZE: begin
            if (status.p_lt_req) cmd.op = OP_P_STEP;
            else state_in = ST_KSIZE;
         end
         ST_KSIZE: begin
            if (status.mb_ge_p) begin
               cmd.op   = OP_S_INIT;
               state_in = ST_S_WAIT;
            end else if (status.kexp_last) begin
               state_in = ST_DONE_FAIL;
            end else begin
               cmd.op = OP_K_STEP;
            end
         end
         ST_S_WAIT: state_in = ST_S_EVAL;
         ST_S_EVAL: begin
            if (!status.cnt_ge_k) begin
               state_in = ST_S_BACK;
            end else if (status.at_target) begin
               cmd.op   = OP_FOUND;
               state_in = ST_U_WAIT;
            end else begin
               cmd.op   = OP_S_DOWN;
               state_in = ST_S_WAIT;
            end
         end
         // A failed right child fails its parent too, so climb before trying a sibling.
         ST_S_BACK: begin
            if (status.node_root) begin
               state_in = ST_DONE_FAIL;
            end else if (status.node_odd) begin
               cmd.op = OP_S_UP;
            end else begin
               cmd.op   = OP_S_NEXT;
               state_in = ST_S_WAIT;
            end
         end
         ST_U_WAIT: state_in = ST_U_WRITE;
         ST_U_WRITE: begin
            cmd.op = OP_U_STEP;
            if (status.node_root) state_in = status.func ? ST_DONE_REL : ST_DONE_ALLOC;
            else state_in = ST_U_WAIT;
         end
         ST_R_DIV: begin
            cmd.op   = OP_DIV_STEP;
            state_in = ST_R_ORD;
         end
         ST_R_ORD: state_in = ST_R_OWN;
         ST_R_OWN: begin
            cmd.op   = OP_OWN_LOAD;
            state_in = ST_R_DEPTH;
         end
         ST_R_DEPTH: begin
            if (status.own_zero) begin
               state_in = ST_DONE_REL;
            end else if (status.node_root) begin
               cmd.op   = OP_R_START;
               state_in = ST_U_WAIT;
            end else begin
               cmd.op = OP_D_STEP;
            end
         end
         ST_DONE_ALLOC: begin
            if (status.rsp_free) begin
               cmd.op   = OP_ALLOC_OK;
               state_in = ST_IDLE;
            end
         end
         ST_DONE_REL: begin
            if (status.rsp_free) begin
               cmd.op   = OP_REL_OK;
               state_in = ST_IDLE;
            end
         end
         ST_DONE_FAIL: begin
            if (status.rsp_free) begin
               cmd.op   = OP_FAIL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

[sv/buddy_tree_allocator_top.sv]
// Top level of the buddy tree allocator: joins controller and datapath and
// drives the configuration port. Uses bta_pkg, bta_ctrl and bta_dpath.

// One request at a time. After reset a clearing pass writes every tree count
// before the first request is taken. An allocation sizes the request, searches
// the tree for a node of that size (backtracking when a branch fails) and
// updates the counts on the way back to the root. A release turns the offset
// into a leaf and reads its owner, climbs level by level to find the block
// size, then updates the counts on the way to the root. The count memory is
// single-port with a registered read. A request refused for its size answers
// from the check state; one refused for lack of space answers once its search
// has run out.
module buddy_tree_allocator_top
   import bta_pkg::*;
#(
   parameter int LEVELS          = LEVELS_DEF,
   parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [REQ_W-1:0]  req_request_bytes,
   input  logic [OFF_W-1:0]  req_release_offset,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_granted,
   output logic [OFF_W-1:0]  rsp_block_offset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MAXB_W-1:0] csr_max_block_bytes
);

   bta_cmd_type    cmd;
   bta_status_type status;

   assign csr_ready = 1'b1;

   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bta_dpath #(
      .LEVELS          (LEVELS),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_request_bytes   (req_request_bytes),
      .req_release_offset  (req_release_offset),
      .csr_write           (csr_valid && csr_ready),
      .csr_max_block_bytes (csr_max_block_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted         (rsp_granted),
      .rsp_block_offset    (rsp_block_offset)
   );

endmodule
